// ===== rtl/mmc_pkg.sv =====
// ============================================================================
// mmc_pkg
// Shared types and constants for the two-way motor move controller: item
// codes, pin layout, the command record passed from front to back, and the
// constants of the move length arithmetic.
// ============================================================================
package mmc_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        OP_POLL       = 2'd0,
        OP_MOVE_LEFT  = 2'd1,
        OP_MOVE_RIGHT = 2'd2
    } op_t;

    // Move direction of the back end.
    typedef enum logic [1:0] {
        DIR_IDLE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    // Sampled pins, left free flag in the lowest bit.
    typedef struct packed {
        logic right_button;
        logic left_button;
        logic right_free;
        logic left_free;
    } pins_t;

    localparam int STEP_W      = 20;
    localparam int AMOUNT_W    = 8;
    localparam int TIME_W      = 32;
    localparam int PROD_W      = STEP_W + AMOUNT_W;
    // Largest quotient is 1048575 * 255 / 100 = 2673866, which needs 22 bits.
    localparam int LEN_W       = 22;

    localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(5000);
    localparam logic [AMOUNT_W-1:0] BUTTON_SHARE = AMOUNT_W'(25);

    // Divide by 100 as a multiply by ceil(2^35 / 100) and a shift by 35.
    // The rounding error (32) stays below 2^(35-28), so it is exact for
    // every 28-bit product.
    localparam int RECIP_SHIFT = 35;
    localparam int RECIP_W     = 29;
    localparam int QPROD_W     = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(343597384);

    // Command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 3);

    // One classified item as the back end consumes it.
    typedef struct packed {
        op_t                op;
        logic [TIME_W-1:0]  now_ms;
        pins_t              pins;
        logic [LEN_W-1:0]   len_ms;
    } cmd_t;

endpackage

// ===== rtl/mmc_front.sv =====
// ============================================================================
// mmc_front
// Front end: holds the step time register, classifies each accepted beat,
// and works out the move length step_time_ms * percent / 100 over two
// register stages (multiply, then divide by a reciprocal multiply).
// ============================================================================
module mmc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mmc_pkg::STEP_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    input  mmc_pkg::op_t                  in_op,
    input  logic [mmc_pkg::TIME_W-1:0]    in_now_ms,
    input  mmc_pkg::pins_t                in_pins,
    input  logic [mmc_pkg::AMOUNT_W-1:0]  in_amount,
    output logic                          out_valid,
    output mmc_pkg::cmd_t                 out_cmd,
    output logic [1:0]                    inflight
);

    logic [mmc_pkg::STEP_W-1:0]   step_time_reg;
    logic [mmc_pkg::AMOUNT_W-1:0] pct;

    logic                         a_valid_reg;
    mmc_pkg::op_t                 a_op_reg;
    logic [mmc_pkg::TIME_W-1:0]   a_now_reg;
    mmc_pkg::pins_t               a_pins_reg;
    logic [mmc_pkg::PROD_W-1:0]   a_prod_reg;
    logic [mmc_pkg::PROD_W-1:0]   a_prod_next;

    logic                         b_valid_reg;
    mmc_pkg::cmd_t                b_cmd_reg;
    logic [mmc_pkg::QPROD_W-1:0]  qprod;

    // Step time register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= mmc_pkg::STEP_RESET;
        end else if (cfg_we) begin
            step_time_reg <= cfg_wdata;
        end
    end

    // A poll may start a button move, which always uses the fixed share.
    assign pct = (in_op == mmc_pkg::OP_POLL) ? mmc_pkg::BUTTON_SHARE : in_amount;
    assign a_prod_next = mmc_pkg::PROD_W'(step_time_reg) * mmc_pkg::PROD_W'(pct);

    // Stage A: capture the item and the raw product.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        a_op_reg   <= in_op;
        a_now_reg  <= in_now_ms;
        a_pins_reg <= in_pins;
        a_prod_reg <= a_prod_next;
    end

    // Stage B: divide by 100 through the reciprocal.
    assign qprod = mmc_pkg::QPROD_W'(a_prod_reg) * mmc_pkg::QPROD_W'(mmc_pkg::RECIP_100);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        b_cmd_reg.op     <= a_op_reg;
        b_cmd_reg.now_ms <= a_now_reg;
        b_cmd_reg.pins   <= a_pins_reg;
        b_cmd_reg.len_ms <= qprod[mmc_pkg::RECIP_SHIFT +: mmc_pkg::LEN_W];
    end

    assign out_valid = b_valid_reg;
    assign out_cmd   = b_cmd_reg;
    assign inflight  = {1'b0, a_valid_reg} + {1'b0, b_valid_reg};

endmodule

// ===== rtl/mmc_queue.sv =====
// ============================================================================
// mmc_queue
// Short command queue between front and back. The front never pushes into
// a full queue because the top level only accepts beats it has room for.
// ============================================================================
module mmc_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  mmc_pkg::cmd_t                push_cmd,
    input  logic                         pop,
    output logic                         head_valid,
    output mmc_pkg::cmd_t                head_cmd,
    output logic [mmc_pkg::QCNT_W-1:0]   count
);

    mmc_pkg::cmd_t                 entry_reg [mmc_pkg::QDEPTH];
    logic [mmc_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mmc_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mmc_pkg::QCNT_W-1:0]    count_reg;
    logic [mmc_pkg::QCNT_W-1:0]    count_next;

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + mmc_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - mmc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + mmc_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + mmc_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    // The credit check upstream must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == mmc_pkg::QCNT_W'(mmc_pkg::QDEPTH)) |-> (!push || pop))
        else $error("command queue pushed while full");

endmodule

// ===== rtl/mmc_back.sv =====
// ============================================================================
// mmc_back
// Back end: carries out one queued command per cycle, when its output register
// is empty or read, against the move state (direction, end time, event time,
// latched pins, drive levels) and holds the result beat in that register.
// ============================================================================
module mmc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    input  mmc_pkg::cmd_t         cmd,
    output logic                  cmd_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata
);

    mmc_pkg::dir_t                dir_reg, dir_next;
    logic [mmc_pkg::TIME_W-1:0]   end_time_reg, end_time_next;
    logic [mmc_pkg::TIME_W-1:0]   event_time_reg, event_time_next;
    mmc_pkg::pins_t               pins_reg, pins_next;
    logic [1:0]                   drive_reg, drive_next;

    logic                         out_valid_reg;
    logic [39:0]                  out_data_reg, out_data_next;

    logic                         ready_res, accepted, rvalid;
    logic [mmc_pkg::TIME_W-1:0]   rtime;
    logic [mmc_pkg::TIME_W-1:0]   move_end;
    mmc_pkg::dir_t                start_side;
    logic                         start_req;
    logic                         side_free, side_held, side_running;
    logic                         side_bit;

    assign cmd_pop  = cmd_valid && (!out_valid_reg || m_tready);
    assign move_end = cmd.now_ms + mmc_pkg::TIME_W'(cmd.len_ms);

    // Move state update for the command at the head of the queue.
    always_comb begin
        dir_next        = dir_reg;
        end_time_next   = end_time_reg;
        event_time_next = event_time_reg;
        pins_next       = pins_reg;
        drive_next      = drive_reg;
        ready_res       = 1'b0;
        accepted        = 1'b0;
        rvalid          = 1'b0;
        rtime           = '0;
        start_req       = 1'b0;
        start_side      = mmc_pkg::DIR_LEFT;
        side_free       = 1'b0;
        side_held       = 1'b0;
        side_bit        = 1'b0;

        unique case (cmd.op)
            mmc_pkg::OP_POLL: begin
                pins_next = cmd.pins;
                // The running side's pins decide whether the move goes on.
                side_bit  = (dir_reg == mmc_pkg::DIR_RIGHT);
                side_free = side_bit ? cmd.pins.right_free : cmd.pins.left_free;
                side_held = side_bit ? cmd.pins.right_button : cmd.pins.left_button;
                unique case (dir_reg) inside
                    mmc_pkg::DIR_LEFT, mmc_pkg::DIR_RIGHT: begin
                        if (side_free && (cmd.now_ms < end_time_reg)) begin
                            drive_next[side_bit] = 1'b1;
                        end else if (!side_held || !side_free) begin
                            drive_next[side_bit] = 1'b0;
                            dir_next             = mmc_pkg::DIR_IDLE;
                            event_time_next      = cmd.now_ms - event_time_reg;
                        end
                    end
                    mmc_pkg::DIR_IDLE: begin
                        if (event_time_reg != '0) begin
                            rvalid          = 1'b1;
                            rtime           = event_time_reg;
                            event_time_next = '0;
                        end else if (cmd.pins.left_button) begin
                            start_req  = 1'b1;
                            start_side = mmc_pkg::DIR_LEFT;
                        end else if (cmd.pins.right_button) begin
                            start_req  = 1'b1;
                            start_side = mmc_pkg::DIR_RIGHT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mmc_pkg::OP_MOVE_LEFT: begin
                start_req  = 1'b1;
                start_side = mmc_pkg::DIR_LEFT;
            end
            mmc_pkg::OP_MOVE_RIGHT: begin
                start_req  = 1'b1;
                start_side = mmc_pkg::DIR_RIGHT;
            end
            default: begin
            end
        endcase

        // A move starts only from idle with the side's latched free flag set.
        if (start_req && (dir_reg == mmc_pkg::DIR_IDLE)) begin
            if ((start_side == mmc_pkg::DIR_LEFT) ? pins_next.left_free
                                                  : pins_next.right_free) begin
                dir_next        = start_side;
                end_time_next   = move_end;
                event_time_next = cmd.now_ms;
                accepted        = 1'b1;
            end
        end

        if (cmd.op == mmc_pkg::OP_POLL) begin
            ready_res = (dir_next == mmc_pkg::DIR_IDLE) && (event_time_next == '0);
        end

        // Result beat: drives, ready, accepted, report flag, duration.
        out_data_next = {3'b000, rtime, rvalid, accepted, ready_res,
                         drive_next[1], drive_next[0]};
    end

    assign side_running = (dir_reg != mmc_pkg::DIR_IDLE);

    // State registers, updated once per popped command.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg        <= mmc_pkg::DIR_IDLE;
            end_time_reg   <= '0;
            event_time_reg <= '0;
            pins_reg       <= '0;
            drive_reg      <= '0;
        end else if (cmd_pop) begin
            dir_reg        <= dir_next;
            end_time_reg   <= end_time_next;
            event_time_reg <= event_time_next;
            pins_reg       <= pins_next;
            drive_reg      <= drive_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd_pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The two motors are never driven together.
    a_one_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(drive_reg[0] && drive_reg[1]))
        else $error("both drives high");

    // A raised drive belongs to a move in progress.
    a_drive_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        (drive_reg != 2'b00) |-> side_running)
        else $error("drive high while idle");

    // A popped command always leaves a result beat behind it.
    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |=> out_valid_reg)
        else $error("popped command produced no result");

    // A report and a move start never share one result beat.
    a_report_or_start: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg[3] && out_data_reg[4]))
        else $error("report and move start in one beat");

endmodule

// ===== rtl/two_way_motor_move_controller.sv =====
// ============================================================================
// two_way_motor_move_controller
// Left/right actuator move controller: a front end computes move lengths,
// a queue decouples it from the back end that runs the move state.
// ============================================================================
// Path: a result beat shows on m_tvalid once its accepted input beat has
// passed front stage A, front stage B, the queue and the output register.
// Throughput: one beat per cycle while m_tready takes each result beat.
// s_tready is held low once the queue plus front stages hold four beats.
// Reset: synchronous on aresetn low; the move state, queue and pipeline
// clear, and the step time returns to 5000 ms.
module two_way_motor_move_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] now_ms, [32] left_free, [33] right_free, [34] left_button,
    // [35] right_button, [43:36] amount, [47:44] zero
    input  logic [47:0] s_tdata,
    // [1:0] op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] left_drive, [1] right_drive, [2] ready_res, [3] move_accepted,
    // [4] report_valid, [36:5] last_action_ms, [39:37] zero
    output logic [39:0] m_tdata
);

    logic                         in_beat;
    mmc_pkg::pins_t               in_pins;
    logic                         f_valid;
    mmc_pkg::cmd_t                f_cmd;
    logic [1:0]                   f_inflight;
    logic                         q_valid;
    mmc_pkg::cmd_t                q_cmd;
    logic [mmc_pkg::QCNT_W-1:0]   q_count;
    logic                         q_pop;

    // Accept only while the queue has room for everything in flight.
    assign s_tready = (q_count + mmc_pkg::QCNT_W'(f_inflight))
                      < mmc_pkg::QCNT_W'(mmc_pkg::QDEPTH);
    assign in_beat  = s_tvalid && s_tready;

    assign in_pins.left_free    = s_tdata[32];
    assign in_pins.right_free   = s_tdata[33];
    assign in_pins.left_button  = s_tdata[34];
    assign in_pins.right_button = s_tdata[35];

    mmc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_beat),
        .in_op     (mmc_pkg::op_t'(s_tuser)),
        .in_now_ms (s_tdata[31:0]),
        .in_pins   (in_pins),
        .in_amount (s_tdata[43:36]),
        .out_valid (f_valid),
        .out_cmd   (f_cmd),
        .inflight  (f_inflight)
    );

    mmc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_valid),
        .push_cmd   (f_cmd),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd),
        .count      (q_count)
    );

    mmc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
